/* design/rdpd_pkg.sv */
`timescale 1ns / 1ps

package rdpd_pkg;

	// Framing characters on the debugger link
	localparam logic [7:0] CH_START = 8'h24;  // '$'
	localparam logic [7:0] CH_END   = 8'h23;  // '#'
	localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
	localparam logic [7:0] CH_NACK  = 8'h2D;  // '-'
	localparam logic [7:0] CH_INTR  = 8'h03;  // break from the debugger

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_BODY  = 4'b0010,
		PH_CK_HI = 4'b0100,
		PH_CK_LO = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		EV_DATA  = 3'd0,
		EV_GOOD  = 3'd1,
		EV_BAD   = 3'd2,
		EV_INTR  = 3'd3,
		EV_STRAY = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		REQ_NONE  = 2'd0,
		REQ_PLUS  = 2'd1,
		REQ_MINUS = 2'd2
	} req_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] sum;
		logic [3:0] hi_digit;
		logic       hi_bad;
	} rdpd_state_t;

	typedef struct packed {
		logic       valid;
		event_t     ev;
		logic [7:0] data;
		req_t       req;
		logic [7:0] sum;
	} rdpd_res_t;

	// {not_hex, digit}; digit is zero for a non-hex byte
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		begin
			if (b >= 8'h30 && b <= 8'h39) begin
				r = {1'b0, b[3:0]};
			end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
				r = {1'b0, b[3:0] + 4'd9};
			end else begin
				r = 5'b10000;
			end
			return r;
		end
	endfunction

endpackage

/* design/rdpd_step.sv */
`timescale 1ns / 1ps

// Next-state and result decode for one received byte.
module rdpd_step import rdpd_pkg::*; (
	input  rdpd_state_t st,
	input  logic [7:0]  rx_b,
	input  logic        no_ack,
	output rdpd_state_t nxt,
	output rdpd_res_t   res
);

	logic [4:0] hv;
	logic       good;

	assign hv   = hex_value(rx_b);
	assign good = !st.hi_bad && !hv[4] && ({st.hi_digit, hv[3:0]} == st.sum);

	always_comb begin
		nxt = st;
		res = '{valid: 1'b0, ev: EV_DATA, data: 8'd0, req: REQ_NONE, sum: 8'd0};
		case (st.phase)
			PH_IDLE: begin
				if (rx_b == CH_ACK || rx_b == CH_NACK) begin
					// late acks from the debugger are dropped silently
				end else if (rx_b == CH_INTR) begin
					res.valid = 1'b1;
					res.ev    = EV_INTR;
					res.req   = REQ_PLUS;
				end else if (rx_b == CH_START) begin
					nxt.sum   = 8'd0;
					nxt.phase = PH_BODY;
				end else begin
					res.valid = 1'b1;
					res.ev    = EV_STRAY;
					res.req   = REQ_MINUS;
				end
			end
			PH_BODY: begin
				if (rx_b == CH_END) begin
					nxt.phase = PH_CK_HI;
				end else begin
					nxt.sum   = st.sum + rx_b;
					res.valid = 1'b1;
					res.ev    = EV_DATA;
					res.data  = rx_b;
				end
			end
			PH_CK_HI: begin
				nxt.hi_bad   = hv[4];
				nxt.hi_digit = hv[3:0];
				nxt.phase    = PH_CK_LO;
			end
			PH_CK_LO: begin
				nxt.phase = PH_IDLE;
				res.valid = 1'b1;
				res.ev    = good ? EV_GOOD : EV_BAD;
				res.req   = good ? REQ_PLUS : REQ_MINUS;
				res.sum   = st.sum;
			end
			default: begin
				nxt.phase = PH_IDLE;
			end
		endcase
		if (no_ack) begin
			res.req = REQ_NONE;
		end
	end

endmodule

/* design/remote_debug_packet_deframer.sv */
`timescale 1ns / 1ps
// Path: a byte accepted into the input register is decoded there, and its result,
//   if it has one, is registered in the result register that drives the result port.
// Throughput: one byte per cycle while rx_stall is low; rx_stall holds a byte
//   that makes a result while a finished result still waits under res_stall.
// Reset (arst_n low, asynchronous): both stages empty, idle phase, sum zero,
//   acks enabled (no_ack_mode 0).

module remote_debug_packet_deframer import rdpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// configuration: no_ack_mode
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	// receive byte channel
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	// result channel
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] event_res,
	output logic [7:0] payload_byte,
	output logic [1:0] status_request,
	output logic [7:0] computed_sum
);

	logic        no_ack_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	rdpd_state_t state_q;
	rdpd_state_t state_nxt;
	rdpd_res_t   res_nxt;
	rdpd_res_t   res_q;
	logic        advance;

	// no-ack mode register; write it only while the deframer is quiet (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_ack_q <= 1'b0;
		end else if (cfg_we) begin
			no_ack_q <= cfg_wdata;
		end
	end

	// Stage 1: input register. A byte leaves it either because it makes no
	// result, or because the result register is free (empty or being taken).
	assign advance  = valid_s1 && (!res_nxt.valid || !res_q.valid || !res_stall);
	assign rx_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	rdpd_step u_step (
		.st     (state_q),
		.rx_b   (byte_s1),
		.no_ack (no_ack_q),
		.nxt    (state_nxt),
		.res    (res_nxt)
	);

	// Framing state moves only when the byte in stage 1 is retired
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, sum: 8'd0, hi_digit: 4'd0, hi_bad: 1'b0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register: holds a request until the consumer drops res_stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (advance && res_nxt.valid) begin
			res_q <= res_nxt;
		end else if (!res_stall) begin
			res_q.valid <= 1'b0;
		end
	end

	assign res_valid      = res_q.valid;
	assign event_res      = res_q.ev;
	assign payload_byte   = res_q.data;
	assign status_request = res_q.req;
	assign computed_sum   = res_q.sum;

endmodule

/* design/rdpd_chk.sv */
`timescale 1ns / 1ps

module rdpd_chk import rdpd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_stall,
	input logic [7:0] rx_byte,
	input logic       res_valid,
	input logic       res_stall,
	input logic [2:0] event_res,
	input logic [7:0] payload_byte,
	input logic [1:0] status_request,
	input logic [7:0] computed_sum
);

	// payload byte only carried with payload events
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res != EV_DATA |-> payload_byte == 8'd0)
		else $error("payload_byte set on a non-payload event");

	// sum only reported at packet end
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res != EV_GOOD && event_res != EV_BAD |-> computed_sum == 8'd0)
		else $error("computed_sum set outside packet end");

	// payload bytes never ask for a status byte
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res == EV_DATA |-> status_request == REQ_NONE)
		else $error("status request on a payload byte");

	// a stalled result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(event_res) && $stable(computed_sum))
		else $error("stalled result changed");

	// a stalled rx request stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && rx_stall |=> rx_valid && $stable(rx_byte))
		else $error("stalled rx request changed");

endmodule

bind remote_debug_packet_deframer rdpd_chk u_rdpd_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.rx_valid       (rx_valid),
	.rx_stall       (rx_stall),
	.rx_byte        (rx_byte),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.event_res      (event_res),
	.payload_byte   (payload_byte),
	.status_request (status_request),
	.computed_sum   (computed_sum)
);
